// ===== hw/rtl/fast_inverse_square_root_assert.svh =====
// ----------------------------------------------------------------------------
// fast_inverse_square_root_assert.svh
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH
`define FAST_INVERSE_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define FISR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define FISR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define FISR_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fisr_pkg.sv =====
// ----------------------------------------------------------------------------
// fisr_pkg
// constants, types and pack/round helpers for the rsqrt pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fisr_pkg;

  localparam logic [31:0] FISR_MAGIC    = 32'h5f3759df;
  localparam logic [31:0] FISR_HALF     = 32'h3f000000;
  localparam logic [31:0] FISR_ONE_HALF = 32'h3fc00000;
  localparam logic [31:0] FISR_QNAN     = 32'h7fc00000;
  localparam logic [7:0]  FISR_EXP_MAX  = 8'hff;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fisr_spec_t;

  typedef struct packed {
    logic       sign;
    logic [7:0] exp;
    logic [23:0] mant;
    fisr_spec_t spec;
  } fisr_unp_t;

  // exponent of a subnormal is taken as 1, hidden bit made explicit
  function automatic fisr_unp_t fisr_unpack(input logic [31:0] f);
    fisr_unp_t u;
    u.sign      = f[31];
    u.exp       = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    u.mant      = {(f[30:23] != 8'd0), f[22:0]};
    u.spec.nan  = (f[30:23] == FISR_EXP_MAX) && (f[22:0] != 23'd0);
    u.spec.inf  = (f[30:23] == FISR_EXP_MAX) && (f[22:0] == 23'd0);
    u.spec.zero = (f[30:23] == 8'd0) && (f[22:0] == 23'd0);
    return u;
  endfunction

  // round to nearest even; the carry runs from fraction into exponent
  function automatic logic [31:0] fisr_round_pack(input logic sign, input logic [9:0] field,
                                                  input logic [23:0] mant, input logic g,
                                                  input logic st);
    logic        rnd;
    logic [32:0] sum;
    rnd = g & (st | mant[0]);
    sum = {field, mant[22:0]} + {32'd0, rnd};
    if (sum[32:23] >= 10'd255) begin
      return {sign, FISR_EXP_MAX, 23'd0};
    end
    return {sign, sum[30:0]};
  endfunction

  function automatic logic [31:0] fisr_special(input logic sign, input fisr_spec_t s);
    if (s.nan) begin
      return FISR_QNAN;
    end else if (s.inf) begin
      return {sign, FISR_EXP_MAX, 23'd0};
    end
    return {sign, 31'd0};
  endfunction

endpackage

// ===== hw/rtl/fisr_fmul.sv =====
// ----------------------------------------------------------------------------
// fisr_fmul
// three-stage single-precision multiplier with a carried side word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fisr_fmul import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] aux_i,
  output logic        vld_o,
  output logic [31:0] p_o,
  output logic [31:0] aux_o
);

  fisr_unp_t          ua, ub;
  logic               v1_r, v2_r, v3_r;
  logic               s1_r, s2_r;
  fisr_spec_t         sp1_r, sp2_r;
  fisr_spec_t         sp1_nxt;
  logic signed [10:0] k1_r, k1_nxt;
  logic [47:0]        prod1_r, prod2_r;
  logic [31:0]        aux1_r, aux2_r, aux3_r;
  logic [5:0]         lz;
  logic signed [10:0] nk;
  logic               left2_r, left2_nxt;
  logic [6:0]         sh2_r, sh2_nxt;
  logic [9:0]         fld2_r, fld2_nxt;
  logic [47:0]        xl;
  logic [95:0]        xr;
  logic [23:0]        mant;
  logic               g, st;
  logic [31:0]        p3_r, p3_nxt;

  // stage 1: unpack and multiply significands
  always_comb begin
    ua = fisr_unpack(a_i);
    ub = fisr_unpack(b_i);
    sp1_nxt.nan  = ua.spec.nan | ub.spec.nan | (ua.spec.inf & ub.spec.zero) |
                   (ua.spec.zero & ub.spec.inf);
    sp1_nxt.inf  = ua.spec.inf | ub.spec.inf;
    sp1_nxt.zero = ua.spec.zero | ub.spec.zero;
    k1_nxt = $signed({3'd0, ua.exp}) + $signed({3'd0, ub.exp}) - 11'sd127;
  end

  // stage 2: leading zeros, choose normal or subnormal alignment
  always_comb begin
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (prod1_r[i]) lz = 6'(47 - i);
    end
    nk = -k1_r;
    left2_nxt = 1'b1;
    sh2_nxt   = {1'b0, lz};
    fld2_nxt  = 10'(k1_r + 11'sd1 - $signed({5'd0, lz}));
    if (k1_r < $signed({5'd0, lz})) begin
      fld2_nxt = 10'd0;
      if (k1_r >= 11'sd0) begin
        sh2_nxt = k1_r[6:0];
      end else begin
        left2_nxt = 1'b0;
        sh2_nxt   = (nk > 11'sd72) ? 7'd72 : nk[6:0];
      end
    end
  end

  // stage 3: shift, round, pack
  always_comb begin
    xl = prod2_r << sh2_r;
    xr = {prod2_r, 48'd0} >> sh2_r;
    if (left2_r) begin
      mant = xl[47:24];
      g    = xl[23];
      st   = |xl[22:0];
    end else begin
      mant = xr[95:72];
      g    = xr[71];
      st   = |xr[70:0];
    end
    if (sp2_r.nan || sp2_r.inf || sp2_r.zero) begin
      p3_nxt = fisr_special(s2_r, sp2_r);
    end else begin
      p3_nxt = fisr_round_pack(s2_r, fld2_r, mant, g, st);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= ua.sign ^ ub.sign;
      sp1_r   <= sp1_nxt;
      k1_r    <= k1_nxt;
      prod1_r <= ua.mant * ub.mant;
      aux1_r  <= aux_i;
      s2_r    <= s1_r;
      sp2_r   <= sp1_r;
      prod2_r <= prod1_r;
      left2_r <= left2_nxt;
      sh2_r   <= sh2_nxt;
      fld2_r  <= fld2_nxt;
      aux2_r  <= aux1_r;
      p3_r    <= p3_nxt;
      aux3_r  <= aux2_r;
    end
  end

  assign vld_o = v3_r;
  assign p_o   = p3_r;
  assign aux_o = aux3_r;

endmodule

// ===== hw/rtl/fisr_fadd.sv =====
// ----------------------------------------------------------------------------
// fisr_fadd
// four-stage single-precision adder with a carried side word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fisr_fadd import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] aux_i,
  output logic        vld_o,
  output logic [31:0] s_o,
  output logic [31:0] aux_o
);

  fisr_unp_t   ua, ub, ubig, usml;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [23:0] mb1_r, ms1_r;
  logic [7:0]  e1_r, e2_r;
  logic [7:0]  d1_r;
  logic        sub1_r, sub2_r;
  logic        sg1_r, sg2_r, sg3_r;
  logic        zs1_r, zs2_r, zs3_r;
  fisr_spec_t  sp1_r, sp2_r, sp3_r;
  fisr_spec_t  sp1_nxt;
  logic [31:0] aux1_r, aux2_r, aux3_r, aux4_r;
  logic [49:0] sm;
  logic [50:0] res2_r, res2_nxt, res3_r;
  logic [5:0]  lz;
  logic [5:0]  sh3_r, sh3_nxt;
  logic [9:0]  fld3_r, fld3_nxt;
  logic [50:0] x;
  logic [31:0] s4_r, s4_nxt;

  // stage 1: unpack, order by magnitude, exponent difference
  always_comb begin
    ua = fisr_unpack(a_i);
    ub = fisr_unpack(b_i);
    if (a_i[30:0] >= b_i[30:0]) begin
      ubig = ua;
      usml = ub;
    end else begin
      ubig = ub;
      usml = ua;
    end
    sp1_nxt.nan  = ua.spec.nan | ub.spec.nan | (ua.spec.inf & ub.spec.inf & (ua.sign ^ ub.sign));
    sp1_nxt.inf  = ua.spec.inf | ub.spec.inf;
    sp1_nxt.zero = 1'b0;
  end

  // stage 2: align smaller operand, far shifts collapse to a sticky bit
  always_comb begin
    if (d1_r > 8'd26) begin
      sm = {49'd0, |ms1_r};
    end else begin
      sm = {ms1_r, 26'd0} >> d1_r;
    end
    if (sub1_r) begin
      res2_nxt = {1'b0, mb1_r, 26'd0} - {1'b0, sm};
    end else begin
      res2_nxt = {1'b0, mb1_r, 26'd0} + {1'b0, sm};
    end
  end

  // stage 3: leading zeros, limited by the subnormal floor
  always_comb begin
    lz = 6'd51;
    for (int i = 0; i < 51; i++) begin
      if (res2_r[i]) lz = 6'(50 - i);
    end
    if ({2'd0, lz} <= e2_r) begin
      sh3_nxt  = lz;
      fld3_nxt = 10'({2'd0, e2_r} + 10'd1 - {4'd0, lz});
    end else begin
      sh3_nxt  = e2_r[5:0];
      fld3_nxt = 10'd0;
    end
  end

  // stage 4: normalize, round, pack
  always_comb begin
    x = res3_r << sh3_r;
    if (sp3_r.nan || sp3_r.inf) begin
      s4_nxt = fisr_special(sg3_r, sp3_r);
    end else if (res3_r == 51'd0) begin
      s4_nxt = {zs3_r, 31'd0};
    end else begin
      s4_nxt = fisr_round_pack(sg3_r, fld3_r, x[50:27], x[26], |x[25:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb1_r  <= ubig.mant;
      ms1_r  <= usml.mant;
      e1_r   <= ubig.exp;
      d1_r   <= ubig.exp - usml.exp;
      sub1_r <= ua.sign ^ ub.sign;
      sg1_r  <= ubig.sign;
      // exact cancellation gives +0, like-signed zeros keep their sign
      zs1_r  <= ua.sign & ub.sign;
      sp1_r  <= sp1_nxt;
      aux1_r <= aux_i;
      res2_r <= res2_nxt;
      e2_r   <= e1_r;
      sub2_r <= sub1_r;
      sg2_r  <= sg1_r;
      zs2_r  <= zs1_r;
      sp2_r  <= sp1_r;
      aux2_r <= aux1_r;
      res3_r <= res2_r;
      sg3_r  <= sg2_r;
      zs3_r  <= zs2_r & ~sub2_r;
      sp3_r  <= sp2_r;
      sh3_r  <= sh3_nxt;
      fld3_r <= fld3_nxt;
      aux3_r <= aux2_r;
      s4_r   <= s4_nxt;
      aux4_r <= aux3_r;
    end
  end

  assign vld_o = v4_r;
  assign s_o   = s4_r;
  assign aux_o = aux4_r;

endmodule

// ===== hw/rtl/fast_inverse_square_root.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// approximate 1/sqrt(x) in single precision: bit-trick guess, one newton step
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_operand_bits take one float bit pattern per item.
//   out_valid/out_stall/out_estimate_bits give one float per item, in order.
//   an item moves on an edge where valid is high and stall is low.
//   the datapath is five float units in a row (multiply, multiply, multiply,
//   add, multiply) of 3, 3, 3, 4 and 3 register stages.
//   one item is taken every cycle unless a stalled result holds the pipeline;
//   throughput is set by the single shared pipeline enable, no unit iterates.
//   when the receiver stalls with a result waiting, the whole pipeline
//   freezes and in_stall rises in the same cycle; nothing is lost.
//   rst_n (synchronous, active low) clears every stage valid bit; items in
//   flight are dropped. any nan result is given as 0x7fc00000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fast_inverse_square_root import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_estimate_bits
);

  logic        en;
  logic [31:0] guess;
  logic        v0, v1, v2, v3;
  logic [31:0] half, y0, t1, y1, t2, y2, t3, y3;

  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // arithmetic shift of the raw bits, then subtract from the magic constant
  assign guess = FISR_MAGIC - {in_operand_bits[31], in_operand_bits[31:1]};

  fisr_fmul u_half (
    .clk, .rst_n, .en,
    .vld_i(in_valid), .a_i(in_operand_bits), .b_i(FISR_HALF), .aux_i(guess),
    .vld_o(v0), .p_o(half), .aux_o(y0)
  );

  fisr_fmul u_t1 (
    .clk, .rst_n, .en,
    .vld_i(v0), .a_i(half), .b_i(y0), .aux_i(y0),
    .vld_o(v1), .p_o(t1), .aux_o(y1)
  );

  fisr_fmul u_t2 (
    .clk, .rst_n, .en,
    .vld_i(v1), .a_i(t1), .b_i(y1), .aux_i(y1),
    .vld_o(v2), .p_o(t2), .aux_o(y2)
  );

  fisr_fadd u_t3 (
    .clk, .rst_n, .en,
    .vld_i(v2), .a_i(FISR_ONE_HALF), .b_i({~t2[31], t2[30:0]}), .aux_i(y2),
    .vld_o(v3), .s_o(t3), .aux_o(y3)
  );

  fisr_fmul u_res (
    .clk, .rst_n, .en,
    .vld_i(v3), .a_i(y3), .b_i(t3), .aux_i(t3),
    .vld_o(out_valid), .p_o(out_estimate_bits), .aux_o()
  );

endmodule

// ===== hw/rtl/fisr_checker.sv =====
// ----------------------------------------------------------------------------
// fisr_checker
// port-level checks of the rsqrt block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fast_inverse_square_root_assert.svh"

module fisr_checker import fisr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_estimate_bits
);

  logic out_nan;
  assign out_nan = (out_estimate_bits[30:23] == FISR_EXP_MAX) &&
                   (out_estimate_bits[22:0] != 23'd0);

  // a held result keeps its value
  `FISR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_estimate_bits), "stalled item changed")

  // pipeline freezes toward the input while a result is held
  `FISR_ASSERT_NOW(a_in_backpressure, out_valid && out_stall, in_stall, "input taken while frozen")

  // never stalls the input without a waiting result
  `FISR_ASSERT_NOW(a_no_spurious_stall, in_stall, out_valid && out_stall, "needless input stall")

  // nan results are always the canonical quiet nan
  `FISR_ASSERT_NOW(a_canon_nan, out_valid && out_nan, out_estimate_bits == FISR_QNAN, "non-canonical nan")

  // reset empties the pipeline
  `FISR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result after reset")

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (.*);

// ===== test/fast_inverse_square_root_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_tb
// checks the rsqrt pipeline against a bit-exact single-precision predictor
// built from integer soft-float multiply and add with round to nearest even
// ----------------------------------------------------------------------------

module fast_inverse_square_root_tb;
  import fisr_pkg::*;

  class rsqrt_scoreboard;
    logic [31:0] pending_estimates[$];
    int          errors;

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    // value is m * 2^e, m nonzero; round to single precision
    function logic [31:0] round_pack(logic s, int e, logic [63:0] m);
      int          k;
      int          biased;
      int          shift;
      logic [63:0] mant;
      logic [63:0] bits;
      logic        g;
      logic        st;
      k = 0;
      for (int i = 0; i < 64; i++) begin
        if (m[i]) k = i;
      end
      biased = e + k + 127;
      shift  = (biased >= 1) ? k - 23 : -149 - e;
      if (shift <= 0) begin
        mant = m << (-shift);
        g    = 1'b0;
        st   = 1'b0;
      end else if (shift > 62) begin
        mant = 64'd0;
        g    = 1'b0;
        st   = 1'b1;
      end else begin
        mant = m >> shift;
        g    = m[shift-1];
        st   = (m & ((64'd1 << (shift - 1)) - 64'd1)) != 64'd0;
      end
      // hidden bit carries into the exponent field
      bits = ((biased >= 1) ? 64'(biased - 1) : 64'd0);
      bits = (bits << 23) + mant;
      bits = bits + 64'(g & (st | mant[0]));
      if (bits >= 64'h7f800000) return {s, FISR_EXP_MAX, 23'd0};
      return {s, bits[30:0]};
    endfunction

    function int exp_of(logic [31:0] f);
      return ((f[30:23] == 8'd0) ? 1 : int'(f[30:23])) - 150;
    endfunction

    function logic [63:0] mant_of(logic [31:0] f);
      return {40'd0, (f[30:23] != 8'd0), f[22:0]};
    endfunction

    function logic is_nan(logic [31:0] f);
      return f[30:23] == FISR_EXP_MAX && f[22:0] != 23'd0;
    endfunction

    function logic is_inf(logic [31:0] f);
      return f[30:0] == {FISR_EXP_MAX, 23'd0};
    endfunction

    function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return FISR_QNAN;
      if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
        return FISR_QNAN;
      if (is_inf(a) || is_inf(b)) return {s, FISR_EXP_MAX, 23'd0};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
      return round_pack(s, exp_of(a) + exp_of(b), mant_of(a) * mant_of(b));
    endfunction

    function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      int          d;
      int          e;
      longint      va;
      longint      vb;
      longint      total;
      if (is_nan(a) || is_nan(b)) return FISR_QNAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FISR_QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      if (exp_of(a) < exp_of(b)) begin
        t = a;
        a = b;
        b = t;
      end
      d = exp_of(a) - exp_of(b);
      // far smaller operand only matters as a sticky bit
      if (d > 35) begin
        va = longint'(mant_of(a) << 35);
        vb = 1;
        e  = exp_of(a) - 35;
      end else begin
        va = longint'(mant_of(a) << d);
        vb = longint'(mant_of(b));
        e  = exp_of(b);
      end
      total = (a[31] ? -va : va) + (b[31] ? -vb : vb);
      if (total == 0) return 32'd0;
      if (total < 0) return round_pack(1'b1, e, 64'(-total));
      return round_pack(1'b0, e, 64'(total));
    endfunction

    function logic [31:0] rsqrt_estimate(logic [31:0] x);
      logic [31:0] half;
      logic [31:0] y;
      logic [31:0] r;
      half = fmul(x, FISR_HALF);
      y    = FISR_MAGIC - {x[31], x[31:1]};
      r    = fmul(y, fadd(FISR_ONE_HALF, fmul(fmul(half, y), y) ^ 32'h80000000));
      return is_nan(r) ? FISR_QNAN : r;
    endfunction

    function void note_operand(logic [31:0] x);
      pending_estimates.push_back(rsqrt_estimate(x));
    endfunction

    function void check_estimate(logic [31:0] got);
      logic [31:0] want;
      if (pending_estimates.size() == 0) begin
        report("unexpected item", got, 32'd0);
        return;
      end
      want = pending_estimates.pop_front();
      if (got !== want) report("estimate_bits", got, want);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_operand_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_estimate_bits;

  rsqrt_scoreboard sb = new();
  logic            in_taken;
  int              send_idle_pct;
  int              stall_pct;

  fast_inverse_square_root i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operand_bits   (in_operand_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_estimate_bits (out_estimate_bits)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // handshakes are judged at the falling edge, clear of the rising-edge updates
  always @(negedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) sb.note_operand(in_operand_bits);
    if (rst_n && out_valid && !out_stall) sb.check_estimate(out_estimate_bits);
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_operand(input logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= x;
    @(posedge clk);
    while (!in_taken) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: x[31:30] = 2'b00;            // ordinary positive values
      4:          x[30:23] = 8'd0;             // subnormals
      5:          x[30:23] = FISR_EXP_MAX;     // infinities and nans
      6:          x[22:0]  = 23'd0;            // exact powers of two
      default: ;
    endcase
    return x;
  endfunction

  initial begin
    logic [31:0] directed[$];
    int          waited;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operand_bits <= 32'd0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    directed = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
                 32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff, 32'h00800000,
                 32'h7f7fffff, 32'h3f800000, 32'h40800000, 32'hbf800000, 32'h80000001,
                 32'h5f3759df, 32'h3e800000, 32'h7effffff, 32'h55555555, 32'haaaaaaaa};
    foreach (directed[i]) send_operand(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      repeat (383) send_operand(random_operand());
    end
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_estimates.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_estimates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
